// ===== sv/stt_pkg.sv =====
// shared types, token codes and sizes for the source tokenizer
package stt_pkg;

   localparam int POSITION_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH           = 4;
   localparam int QUEUE_PTR_BITS        = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS        = $clog2(QUEUE_DEPTH + 1);

   // token codes
   localparam logic [4:0] TOK_IDENT  = 5'd0;
   localparam logic [4:0] TOK_NUMBER = 5'd1;
   localparam logic [4:0] TOK_INT    = 5'd2;
   localparam logic [4:0] TOK_IF     = 5'd3;
   localparam logic [4:0] TOK_ELSE   = 5'd4;
   localparam logic [4:0] TOK_WHILE  = 5'd5;
   localparam logic [4:0] TOK_PRINT  = 5'd6;
   localparam logic [4:0] TOK_PLUS   = 5'd7;
   localparam logic [4:0] TOK_MINUS  = 5'd8;
   localparam logic [4:0] TOK_STAR   = 5'd9;
   localparam logic [4:0] TOK_SLASH  = 5'd10;
   localparam logic [4:0] TOK_ASSIGN = 5'd11;
   localparam logic [4:0] TOK_SEMI   = 5'd12;
   localparam logic [4:0] TOK_LPAREN = 5'd13;
   localparam logic [4:0] TOK_RPAREN = 5'd14;
   localparam logic [4:0] TOK_LBRACE = 5'd15;
   localparam logic [4:0] TOK_RBRACE = 5'd16;
   localparam logic [4:0] TOK_END    = 5'd17;

   // input beat kinds
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_EOS  = 1'b1;

   typedef struct packed {
      logic [4:0]  kind;
      logic [15:0] line;
      logic [15:0] column;
      logic [15:0] length;
      logic [7:0]  first_char;
      logic        last;
   } stt_token_type;

   // tokens handed from the scanner to the queue, compacted into tok0 first
   typedef struct packed {
      logic [1:0]    count;
      stt_token_type tok0;
      stt_token_type tok1;
   } stt_push_type;

endpackage

// ===== sv/stt_front.sv =====
// scanner: classifies source bytes, tracks position and builds tokens
module stt_front #(
   parameter int POSITION_BITS = stt_pkg::POSITION_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic                 kind,
   input  logic [7:0]           ch,
   output stt_pkg::stt_push_type push
);
   import stt_pkg::*;

   localparam logic [1:0] MODE_IDLE   = 2'd0;
   localparam logic [1:0] MODE_IDENT  = 2'd1;
   localparam logic [1:0] MODE_NUMBER = 2'd2;

   localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);
   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

   logic [1:0]               mode_ff, mode_in;
   logic [POSITION_BITS-1:0] line_ff, line_in;
   logic [POSITION_BITS-1:0] col_ff, col_in;
   logic [POSITION_BITS-1:0] sline_ff, sline_in;
   logic [POSITION_BITS-1:0] scol_ff, scol_in;
   logic [POSITION_BITS-1:0] plen_ff, plen_in;
   logic [39:0]              prefix_ff, prefix_in;

   logic          is_alpha, is_digit, is_space, pending;
   logic [4:0]    kw_kind, punct_kind;
   logic [POSITION_BITS-1:0] line_step, col_step, plen_step;
   stt_token_type flush_tok, t0, t1;
   logic          v0, v1;

   function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] v);
      return (v == POS_MAX) ? v : v + POS_ONE;
   endfunction

   assign is_alpha = (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z") || ch == "_";
   assign is_digit = ch >= "0" && ch <= "9";
   assign is_space = ch == " " || ch == 8'h09 || ch == 8'h0d || ch == 8'h0a;
   assign pending  = mode_ff == MODE_IDENT || mode_ff == MODE_NUMBER;

   // position after this byte
   assign line_step = (ch == 8'h0a) ? sat_inc(line_ff) : line_ff;
   assign col_step  = (ch == 8'h0a) ? POS_ONE : sat_inc(col_ff);
   assign plen_step = sat_inc(plen_ff);

   // keyword needs exact length and exact text
   always_comb begin
      kw_kind = TOK_IDENT;
      if (plen_ff == POSITION_BITS'(3) && prefix_ff == {16'h0, "t", "n", "i"})
         kw_kind = TOK_INT;
      else if (plen_ff == POSITION_BITS'(2) && prefix_ff == {24'h0, "f", "i"})
         kw_kind = TOK_IF;
      else if (plen_ff == POSITION_BITS'(4) && prefix_ff == {8'h0, "e", "s", "l", "e"})
         kw_kind = TOK_ELSE;
      else if (plen_ff == POSITION_BITS'(5) && prefix_ff == {"e", "l", "i", "h", "w"})
         kw_kind = TOK_WHILE;
      else if (plen_ff == POSITION_BITS'(5) && prefix_ff == {"t", "n", "i", "r", "p"})
         kw_kind = TOK_PRINT;
   end

   always_comb begin
      unique case (ch)
         "+":     punct_kind = TOK_PLUS;
         "-":     punct_kind = TOK_MINUS;
         "*":     punct_kind = TOK_STAR;
         "/":     punct_kind = TOK_SLASH;
         "=":     punct_kind = TOK_ASSIGN;
         ";":     punct_kind = TOK_SEMI;
         "(":     punct_kind = TOK_LPAREN;
         ")":     punct_kind = TOK_RPAREN;
         "{":     punct_kind = TOK_LBRACE;
         "}":     punct_kind = TOK_RBRACE;
         default: punct_kind = TOK_IDENT;
      endcase
   end

   always_comb begin
      flush_tok.kind       = (mode_ff == MODE_IDENT) ? kw_kind : TOK_NUMBER;
      flush_tok.line       = 16'(sline_ff);
      flush_tok.column     = 16'(scol_ff);
      flush_tok.length     = 16'(plen_ff);
      flush_tok.first_char = prefix_ff[7:0];
      flush_tok.last       = 1'b0;
   end

   always_comb begin
      mode_in   = mode_ff;
      line_in   = line_ff;
      col_in    = col_ff;
      sline_in  = sline_ff;
      scol_in   = scol_ff;
      plen_in   = plen_ff;
      prefix_in = prefix_ff;
      v0        = 1'b0;
      v1        = 1'b0;
      t0        = flush_tok;
      t1        = '0;
      if (accept) begin
         if (kind == KIND_EOS) begin
            v0        = pending;
            v1        = 1'b1;
            t1.kind   = TOK_END;
            t1.line   = 16'(line_ff);
            t1.column = 16'(col_ff);
            mode_in   = MODE_IDLE;
            line_in   = POS_ONE;
            col_in    = POS_ONE;
            sline_in  = '0;
            scol_in   = '0;
            plen_in   = '0;
            prefix_in = '0;
         end else if (mode_ff == MODE_IDENT && (is_alpha || is_digit)) begin
            if (plen_ff < POSITION_BITS'(5))
               prefix_in[8*plen_ff[2:0] +: 8] = ch;
            plen_in = plen_step;
            line_in = line_step;
            col_in  = col_step;
         end else if (mode_ff == MODE_NUMBER && is_digit) begin
            plen_in = plen_step;
            line_in = line_step;
            col_in  = col_step;
         end else begin
            v0      = pending;
            mode_in = MODE_IDLE;
            line_in = line_step;
            col_in  = col_step;
            if (is_space) begin
               // skipped
            end else if (is_alpha || is_digit) begin
               mode_in   = is_alpha ? MODE_IDENT : MODE_NUMBER;
               sline_in  = line_ff;
               scol_in   = col_ff;
               plen_in   = POS_ONE;
               prefix_in = {32'h0, ch};
            end else begin
               v1            = 1'b1;
               t1.kind       = punct_kind;
               t1.line       = 16'(line_ff);
               t1.column     = 16'(col_ff);
               t1.length     = 16'd1;
               t1.first_char = ch;
            end
         end
      end
      t1.last = 1'b1;
      t0.last = !v1;
      push.count = {1'b0, v0} + {1'b0, v1};
      push.tok0  = v0 ? t0 : t1;
      push.tok1  = t1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         line_ff   <= POS_ONE;
         col_ff    <= POS_ONE;
         sline_ff  <= '0;
         scol_ff   <= '0;
         plen_ff   <= '0;
         prefix_ff <= '0;
      end else begin
         mode_ff   <= mode_in;
         line_ff   <= line_in;
         col_ff    <= col_in;
         sline_ff  <= sline_in;
         scol_ff   <= scol_in;
         plen_ff   <= plen_in;
         prefix_ff <= prefix_in;
      end
   end

endmodule

// ===== sv/stt_queue.sv =====
// token queue taking up to two tokens a cycle, with the registered output stage
module stt_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  stt_pkg::stt_push_type push,
   output logic                  room,
   output logic                  out_valid,
   input  logic                  out_ready,
   output stt_pkg::stt_token_type out_tok
);
   import stt_pkg::*;

   stt_token_type             ent_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ff, wr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ff, rd_in;
   logic [QUEUE_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                      valid_ff, valid_in;
   stt_token_type             tok_ff;
   logic                      pop;

   assign room = cnt_ff <= QUEUE_CNT_BITS'(QUEUE_DEPTH - 2);
   assign pop  = cnt_ff != '0 && (!valid_ff || out_ready);

   assign wr_in    = wr_ff + QUEUE_PTR_BITS'(push.count);
   assign rd_in    = rd_ff + QUEUE_PTR_BITS'(pop);
   assign cnt_in   = cnt_ff + QUEUE_CNT_BITS'(push.count) - QUEUE_CNT_BITS'(pop);
   assign valid_in = pop || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0)
         ent_ff[wr_ff] <= push.tok0;
      if (push.count == 2'd2)
         ent_ff[wr_ff + QUEUE_PTR_BITS'(1)] <= push.tok1;
      if (pop)
         tok_ff <= ent_ff[rd_ff];
   end

   assign out_valid = valid_ff;
   assign out_tok   = tok_ff;

endmodule

// ===== sv/source_tokenizer_unit.sv =====
// source tokenizer top level: scanner front, token queue and output stage
// a completed token is queued, then loaded into the output register behind rsp_tvalid
// throughput: one source beat per cycle while the 4-entry token queue has room for
//   two tokens; tokens leave the output register one per cycle with rsp_tready high
// reset: position returns to line 1, column 1, no pending token, queue empty
module source_tokenizer_unit #(
   parameter int POSITION_BITS = stt_pkg::POSITION_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // ch
   input  logic        req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // token_line, token_column, token_length, first_char
   output logic [4:0]  rsp_tuser,   // token_type
   output logic        rsp_tlast
);
   import stt_pkg::*;

   stt_push_type  push;
   stt_token_type out_tok;
   logic          room;

   assign req_tready = room;

   stt_front #(
      .POSITION_BITS(POSITION_BITS)
   ) u_front (
      .clock (clock),
      .reset (reset),
      .accept(req_tvalid && room),
      .kind  (req_tuser),
      .ch    (req_tdata),
      .push  (push)
   );

   stt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .room     (room),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_tok  (out_tok)
   );

   assign rsp_tdata = {out_tok.first_char, out_tok.length, out_tok.column, out_tok.line};
   assign rsp_tuser = out_tok.kind;
   assign rsp_tlast = out_tok.last;

endmodule

// ===== dv/tb_source_tokenizer_unit.sv =====
// self-checking testbench for the source tokenizer: directed table and random text
`timescale 1ns / 1ps

module tb_source_tokenizer_unit;
   import stt_pkg::*;

   localparam int CYCLE_LIMIT = 20_000;
   localparam int RANDOM_BEATS = 200;

   typedef enum logic [1:0] {SCAN_IDLE, SCAN_IDENT, SCAN_NUMBER} scan_mode_type;

   typedef struct packed {
      logic          kind;
      logic [7:0]    ch;
      logic          typed;
      stt_token_type want;
   } plan_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;   // ch
   logic        req_tuser = 1'b0;   // kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;          // token_line, token_column, token_length, first_char
   logic [4:0]  rsp_tuser;          // token_type
   logic        rsp_tlast;

   // predictor state
   scan_mode_type mode;
   logic [15:0] cur_line, cur_col, tok_line, tok_col, tok_len;
   logic [39:0] word;
   logic [7:0]  tok_first;

   stt_token_type step_tokens[$];
   stt_token_type pending_tokens[$];
   plan_row_type  plan[$];

   int  token_errors = 0;
   int  tokens_seen = 0;
   int  beats_sent = 0;
   int  cycles = 0;
   bit  calm = 1'b0;

   source_tokenizer_unit uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d tokens outstanding", cycles,
                  pending_tokens.size());
         $display("tb_source_tokenizer_unit NOT OK");
         $finish;
      end
   end

   function automatic logic [15:0] bump(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function automatic stt_token_type make_token(input logic [4:0] code, input logic [15:0] ln,
                                                input logic [15:0] cl, input logic [15:0] len,
                                                input logic [7:0] first);
      stt_token_type t;
      t.kind = code;
      t.line = ln;
      t.column = cl;
      t.length = len;
      t.first_char = first;
      t.last = 1'b0;
      return t;
   endfunction

   function automatic void clear_scan();
      mode = SCAN_IDLE;
      cur_line = 16'd1;
      cur_col = 16'd1;
      tok_line = 16'd0;
      tok_col = 16'd0;
      tok_len = 16'd0;
      word = 40'd0;
      tok_first = 8'd0;
   endfunction

   function automatic void advance(input logic [7:0] c);
      if (c == 8'h0A) begin
         cur_line = bump(cur_line);
         cur_col = 16'd1;
      end else begin
         cur_col = bump(cur_col);
      end
   endfunction

   // keywords need the exact length as well as the first five bytes
   function automatic logic [4:0] word_code();
      if (tok_len == 16'd3 && word == {16'd0, "int"}) return TOK_INT;
      if (tok_len == 16'd2 && word == {24'd0, "if"}) return TOK_IF;
      if (tok_len == 16'd4 && word == {8'd0, "else"}) return TOK_ELSE;
      if (tok_len == 16'd5 && word == "while") return TOK_WHILE;
      if (tok_len == 16'd5 && word == "print") return TOK_PRINT;
      return TOK_IDENT;
   endfunction

   function automatic logic [4:0] punct_code(input logic [7:0] c);
      case (c)
         "+": return TOK_PLUS;
         "-": return TOK_MINUS;
         "*": return TOK_STAR;
         "/": return TOK_SLASH;
         "=": return TOK_ASSIGN;
         ";": return TOK_SEMI;
         "(": return TOK_LPAREN;
         ")": return TOK_RPAREN;
         "{": return TOK_LBRACE;
         "}": return TOK_RBRACE;
         default: return TOK_IDENT;
      endcase
   endfunction

   function automatic void flush_pending();
      if (mode == SCAN_IDENT)
         step_tokens.push_back(make_token(word_code(), tok_line, tok_col, tok_len, tok_first));
      else if (mode == SCAN_NUMBER)
         step_tokens.push_back(make_token(TOK_NUMBER, tok_line, tok_col, tok_len, tok_first));
      mode = SCAN_IDLE;
   endfunction

   // works out the tokens one accepted beat gives, into step_tokens
   function automatic void scan_source_beat(input logic k, input logic [7:0] c);
      logic alpha, digit, blank;
      stt_token_type tail;
      alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
      digit = c >= "0" && c <= "9";
      blank = c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A;
      step_tokens.delete();
      if (k == KIND_EOS) begin
         flush_pending();
         step_tokens.push_back(make_token(TOK_END, cur_line, cur_col, 16'd0, 8'd0));
         clear_scan();
      end else if (mode == SCAN_IDENT && (alpha || digit)) begin
         if (tok_len < 16'd5) word = {word[31:0], c};
         tok_len = bump(tok_len);
         advance(c);
      end else if (mode == SCAN_NUMBER && digit) begin
         tok_len = bump(tok_len);
         advance(c);
      end else begin
         flush_pending();
         if (alpha || digit) begin
            mode = alpha ? SCAN_IDENT : SCAN_NUMBER;
            tok_line = cur_line;
            tok_col = cur_col;
            tok_len = 16'd1;
            word = {32'd0, c};
            tok_first = c;
         end else if (!blank) begin
            step_tokens.push_back(make_token(punct_code(c), cur_line, cur_col, 16'd1, c));
         end
         advance(c);
      end
      if (step_tokens.size() != 0) begin
         tail = step_tokens.pop_back();
         tail.last = 1'b1;
         step_tokens.push_back(tail);
      end
   endfunction

   task automatic send_source_beat(input logic k, input logic [7:0] c, input logic typed,
                                   input stt_token_type want);
      while (!calm && $urandom_range(99) < 16) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= k;
      req_tdata <= c;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      scan_source_beat(k, c);
      if (typed) pending_tokens.push_back(want);
      else foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
      beats_sent++;
   endtask

   task automatic send_byte(input logic [7:0] c);
      send_source_beat(KIND_BYTE, c, 1'b0, '0);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic drain_tokens();
      req_tvalid <= 1'b0;
      while (pending_tokens.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   function automatic void add_row(input logic k, input logic [7:0] c, input logic typed,
                                   input logic [4:0] code, input logic [15:0] ln,
                                   input logic [15:0] cl, input logic [15:0] len,
                                   input logic [7:0] first);
      plan_row_type r;
      r.kind = k;
      r.ch = c;
      r.typed = typed;
      r.want = make_token(code, ln, cl, len, first);
      r.want.last = 1'b1;
      plan.push_back(r);
   endfunction

   // a random identifier or word character; the first one may not be a digit
   function automatic logic [7:0] ident_char(input bit first);
      int r;
      r = $urandom_range(first ? 52 : 62);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      if (r == 52) return "_";
      return 8'("0" + r - 53);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
      token_errors++;
   endtask

   task automatic check_token();
      stt_token_type want;
      tokens_seen++;
      if (pending_tokens.size() == 0) begin
         report_mismatch("token beat with nothing expected, type", rsp_tuser, 0);
      end else begin
         want = pending_tokens.pop_front();
         if (rsp_tuser != want.kind) report_mismatch("token_type", rsp_tuser, want.kind);
         if (rsp_tdata[15:0] != want.line)
            report_mismatch("token_line", rsp_tdata[15:0], want.line);
         if (rsp_tdata[31:16] != want.column)
            report_mismatch("token_column", rsp_tdata[31:16], want.column);
         if (rsp_tdata[47:32] != want.length)
            report_mismatch("token_length", rsp_tdata[47:32], want.length);
         if (rsp_tdata[55:48] != want.first_char)
            report_mismatch("first_char", rsp_tdata[55:48], want.first_char);
         if (rsp_tlast != want.last) report_mismatch("last_of_run", rsp_tlast, want.last);
      end
   endtask

   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= calm || $urandom_range(99) >= 16;
      if (!reset && rsp_tvalid && rsp_tready) check_token();
   end

   initial begin
      string near_words[10];
      string puncts;
      int r;
      int n;
      int rand_start;
      near_words = '{"int", "if", "else", "while", "print",
                     "in", "iff", "elsewhere", "whil", "printf"};
      puncts = "+-*/=;(){}";
      clear_scan();

      // directed rows: positions before the newline are easy to read off
      add_row(KIND_EOS,  8'hA5, 1'b1, TOK_END,    16'd1, 16'd1,  16'd0, 8'd0);
      add_row(KIND_BYTE, "+",   1'b1, TOK_PLUS,   16'd1, 16'd1,  16'd1, "+");
      add_row(KIND_BYTE, "-",   1'b1, TOK_MINUS,  16'd1, 16'd2,  16'd1, "-");
      add_row(KIND_BYTE, "*",   1'b1, TOK_STAR,   16'd1, 16'd3,  16'd1, "*");
      add_row(KIND_BYTE, "/",   1'b1, TOK_SLASH,  16'd1, 16'd4,  16'd1, "/");
      add_row(KIND_BYTE, "=",   1'b1, TOK_ASSIGN, 16'd1, 16'd5,  16'd1, "=");
      add_row(KIND_BYTE, ";",   1'b1, TOK_SEMI,   16'd1, 16'd6,  16'd1, ";");
      add_row(KIND_BYTE, "(",   1'b1, TOK_LPAREN, 16'd1, 16'd7,  16'd1, "(");
      add_row(KIND_BYTE, ")",   1'b1, TOK_RPAREN, 16'd1, 16'd8,  16'd1, ")");
      add_row(KIND_BYTE, "{",   1'b1, TOK_LBRACE, 16'd1, 16'd9,  16'd1, "{");
      add_row(KIND_BYTE, "}",   1'b1, TOK_RBRACE, 16'd1, 16'd10, 16'd1, "}");
      add_row(KIND_BYTE, 8'h00, 1'b1, TOK_IDENT,  16'd1, 16'd11, 16'd1, 8'h00);
      add_row(KIND_BYTE, 8'hFF, 1'b1, TOK_IDENT,  16'd1, 16'd12, 16'd1, 8'hFF);
      add_row(KIND_BYTE, 8'h09, 1'b0, TOK_IDENT, 16'd0, 16'd0, 16'd0, 8'd0);
      add_row(KIND_BYTE, 8'h0D, 1'b0, TOK_IDENT, 16'd0, 16'd0, 16'd0, 8'd0);
      add_row(KIND_BYTE, 8'h0A, 1'b0, TOK_IDENT, 16'd0, 16'd0, 16'd0, 8'd0);
      add_row(KIND_BYTE, "i",   1'b0, TOK_IDENT, 16'd0, 16'd0, 16'd0, 8'd0);
      add_row(KIND_BYTE, "f",   1'b0, TOK_IDENT, 16'd0, 16'd0, 16'd0, 8'd0);
      add_row(KIND_BYTE, "(",   1'b0, TOK_IDENT, 16'd0, 16'd0, 16'd0, 8'd0);
      add_row(KIND_BYTE, "_",   1'b0, TOK_IDENT, 16'd0, 16'd0, 16'd0, 8'd0);
      add_row(KIND_BYTE, "9",   1'b0, TOK_IDENT, 16'd0, 16'd0, 16'd0, 8'd0);
      add_row(KIND_BYTE, "Z",   1'b0, TOK_IDENT, 16'd0, 16'd0, 16'd0, 8'd0);
      add_row(KIND_BYTE, " ",   1'b0, TOK_IDENT, 16'd0, 16'd0, 16'd0, 8'd0);
      add_row(KIND_BYTE, "0",   1'b0, TOK_IDENT, 16'd0, 16'd0, 16'd0, 8'd0);
      add_row(KIND_BYTE, "A",   1'b0, TOK_IDENT, 16'd0, 16'd0, 16'd0, 8'd0);
      add_row(KIND_EOS,  8'h5A, 1'b0, TOK_IDENT, 16'd0, 16'd0, 16'd0, 8'd0);
      add_row(KIND_BYTE, "5",   1'b0, TOK_IDENT, 16'd0, 16'd0, 16'd0, 8'd0);
      add_row(KIND_EOS,  8'h00, 1'b0, TOK_IDENT, 16'd0, 16'd0, 16'd0, 8'd0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) send_source_beat(plan[i].kind, plan[i].ch, plan[i].typed, plan[i].want);
      drain_tokens();

      // random source text: mostly well-formed words, with noise bytes and early ends
      rand_start = beats_sent;
      while (beats_sent - rand_start < RANDOM_BEATS) begin
         calm = (beats_sent - rand_start >= 80) && (beats_sent - rand_start < 140);
         r = $urandom_range(99);
         if (r < 20) begin
            send_text(near_words[$urandom_range(9)]);
         end else if (r < 45) begin
            n = $urandom_range(1, 8);
            send_byte(ident_char(1'b1));
            repeat (n - 1) send_byte(ident_char(1'b0));
         end else if (r < 60) begin
            repeat ($urandom_range(1, 6)) send_byte(8'("0" + $urandom_range(9)));
         end else if (r < 78) begin
            send_byte(puncts[$urandom_range(9)]);
         end else if (r < 93) begin
            send_byte(8'($urandom_range(255)));
         end else begin
            send_source_beat(KIND_EOS, 8'($urandom_range(255)), 1'b0, '0);
         end
         // half the words are followed by a blank, the rest run into the next one
         if ($urandom_range(1) == 1) begin
            case ($urandom_range(3))
               0: send_byte(" ");
               1: send_byte(8'h09);
               2: send_byte(8'h0D);
               default: send_byte(8'h0A);
            endcase
         end
      end
      calm = 1'b0;
      send_source_beat(KIND_EOS, 8'h00, 1'b0, '0);
      drain_tokens();
      repeat (20) @(posedge clock);

      if (pending_tokens.size() != 0)
         report_mismatch("tokens never delivered", pending_tokens.size(), 0);
      $display("run covered %0d source beats and %0d token beats: every token kind, keywords",
               beats_sent, tokens_seen);
      $display("and near misses, unknown and zero bytes, blanks and early ends of source");
      if (token_errors == 0) begin
         $display("tb_source_tokenizer_unit OK");
      end else begin
         $display("tb_source_tokenizer_unit NOT OK");
      end
      $finish;
   end

endmodule

// ===== source_tokenizer_unit.f =====
sv/stt_pkg.sv
sv/stt_front.sv
sv/stt_queue.sv
sv/source_tokenizer_unit.sv
dv/tb_source_tokenizer_unit.sv
